>>> hdl/ffra_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_pkg
// Shared sizes, status codes and controller/datapath bundles for the
// first-fit range allocator.
// ----------------------------------------------------------------------------
package ffra_pkg;

  localparam int HEAP_SIZE  = 256;
  localparam int FREE_SLOTS = 64;
  localparam int ADDR_W     = $clog2(HEAP_SIZE);
  localparam int LEN_W      = $clog2(HEAP_SIZE + 1);
  localparam int POS_W      = $clog2(FREE_SLOTS);
  localparam int CNT_W      = $clog2(FREE_SLOTS + 1);
  localparam int GEN_W      = 8;
  localparam logic [GEN_W-1:0] GEN_MASK = 8'hFF;

  localparam logic [2:0] ST_OK            = 3'd0;
  localparam logic [2:0] ST_NO_SPACE      = 3'd1;
  localparam logic [2:0] ST_BAD_COUNT     = 3'd2;
  localparam logic [2:0] ST_NOT_ALLOCATED = 3'd3;
  localparam logic [2:0] ST_LIST_FULL     = 3'd4;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;       // capture request
    logic clr_step;   // one step of the block-table clearing pass
    logic scan_rd;    // issue list read at scan index
    logic scan_adv;   // advance scan index
    logic blk_rd;     // read block table at base
    logic alloc_hit;  // commit allocate at scan index
    logic free_go;    // commit free (merge decision taken)
    logic sh_rd;      // read the entry to be moved
    logic sh_wr;      // write the moved entry and step the shift pointer
    logic sh_end;     // close the shift: place new entry, adjust used count
    logic fin;        // write result
    logic [2:0] st;   // status to report
  } ffra_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic clr_done;
    logic scan_end;   // scan index reached used count
    logic fits;       // entry at scan index holds the count
    logic exact;      // entry at scan index holds exactly the count
    logic past;       // entry start >= base
    logic blk_zero;   // no block at base
    logic need_new;   // free needs a new entry
    logic both;       // free joins both neighbours
    logic list_full;
    logic sh_more;    // another entry still has to move
    logic op;
    logic cnt_zero;
  } ffra_sts_t;

endpackage

>>> hdl/ffra_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_in_if / ffra_out_if
// Valid/ready channels for requests and results.
// ----------------------------------------------------------------------------
interface ffra_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [8:0] count;
  logic [7:0] base_index;
  modport source (output valid, op, count, base_index, input ready);
  modport sink   (input valid, op, count, base_index, output ready);
endinterface

interface ffra_out_if;
  logic       valid;
  logic       ready;
  logic [2:0] status;
  logic [7:0] block_start;
  logic [8:0] block_size;
  logic [7:0] generation;
  modport source (output valid, status, block_start, block_size, generation, input ready);
  modport sink   (input valid, status, block_start, block_size, generation, output ready);
endinterface

>>> hdl/ffra_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_datapath
// Free-range list memories, block table, generation counter and result
// register of the allocator.
// ----------------------------------------------------------------------------
module ffra_datapath
  import ffra_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  ffra_cmd_t        cmd,
  output ffra_sts_t        sts,
  input  logic             in_op,
  input  logic [8:0]       in_count,
  input  logic [7:0]       in_base,
  output logic [2:0]       res_status,
  output logic [7:0]       res_start,
  output logic [8:0]       res_size,
  output logic [7:0]       res_gen
);

  // List memories: one write port, registered read
  logic [LEN_W-1:0] rs_mem [FREE_SLOTS];
  logic [LEN_W-1:0] rl_mem [FREE_SLOTS];
  logic [LEN_W-1:0] blk_mem [HEAP_SIZE];

  logic              op_r;
  logic [8:0]        cnt_r;
  logic [ADDR_W-1:0] base_r;
  logic [CNT_W-1:0]  used_r;
  logic [CNT_W-1:0]  idx_r;      // scan index
  logic [CNT_W-1:0]  sh_r;       // shift pointer
  logic              ins_r;      // insert shifts up, remove shifts down
  logic [GEN_W-1:0]  gen_r;
  logic [ADDR_W:0]   clr_r;
  logic [LEN_W-1:0]  cur_s_r, cur_l_r;   // entry at idx
  logic [LEN_W-1:0]  prv_s_r, prv_l_r;   // entry at idx-1
  logic              prv_v_r;
  logic [LEN_W-1:0]  blen_r;
  logic [LEN_W-1:0]  sh_s_r, sh_l_r;
  logic [2:0]        rst_r;
  logic [7:0]        rstart_r;
  logic [8:0]        rsize_r;
  logic [7:0]        rgen_r;

  logic              in_list, jn, jp, exact;
  logic [LEN_W:0]    base_end, prv_end;
  logic [GEN_W-1:0]  gen_nxt;
  logic [POS_W-1:0]  idx_a, idxm1_a, sh_a, src_a;
  logic [CNT_W-1:0]  sh_inc;

  assign idx_a    = idx_r[POS_W-1:0];
  assign idxm1_a  = POS_W'(idx_r - CNT_W'(1));
  assign sh_a     = sh_r[POS_W-1:0];
  assign sh_inc   = sh_r + CNT_W'(1);
  assign src_a    = ins_r ? POS_W'(sh_r - CNT_W'(1)) : sh_inc[POS_W-1:0];
  assign in_list  = (idx_r < used_r);
  assign base_end = {1'b0, LEN_W'(base_r)} + {1'b0, blen_r};
  assign prv_end  = {1'b0, prv_s_r} + {1'b0, prv_l_r};
  assign jn       = in_list && (base_end == {1'b0, cur_s_r});
  assign jp       = prv_v_r && (prv_end == {1'b0, LEN_W'(base_r)});
  assign exact    = cur_l_r == LEN_W'(cnt_r);
  assign gen_nxt  = (gen_r == GEN_MASK) ? GEN_W'(1) : gen_r + GEN_W'(1);

  assign sts.clr_done  = clr_r[ADDR_W];
  assign sts.scan_end  = !in_list;
  assign sts.fits      = cur_l_r >= LEN_W'(cnt_r);
  assign sts.exact     = exact;
  assign sts.past      = cur_s_r >= LEN_W'(base_r);
  assign sts.blk_zero  = blen_r == '0;
  assign sts.need_new  = !jn && !jp;
  assign sts.both      = jn && jp;
  assign sts.list_full = used_r >= CNT_W'(FREE_SLOTS);
  assign sts.sh_more   = ins_r ? (sh_r > idx_r) : (sh_inc < used_r);
  assign sts.op        = op_r;
  assign sts.cnt_zero  = cnt_r == '0;

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r  <= CNT_W'(1);
      gen_r   <= '0;
      clr_r   <= '0;
      idx_r   <= '0;
      prv_v_r <= 1'b0;
      sh_r    <= '0;
      ins_r   <= 1'b0;
    end else begin
      if (cmd.clr_step) clr_r <= clr_r + (ADDR_W+1)'(1);
      if (cmd.load) begin
        idx_r   <= '0;
        prv_v_r <= 1'b0;
      end
      if (cmd.scan_adv) begin
        idx_r   <= idx_r + CNT_W'(1);
        prv_v_r <= 1'b1;
      end
      if (cmd.alloc_hit) begin
        gen_r <= gen_nxt;
        if (exact) begin
          ins_r <= 1'b0;
          sh_r  <= idx_r;
        end
      end
      if (cmd.free_go) begin
        if (jp && jn) begin
          ins_r <= 1'b0;
          sh_r  <= idx_r;
        end else if (!jp && !jn) begin
          ins_r <= 1'b1;
          sh_r  <= used_r;
        end
      end
      if (cmd.sh_wr) sh_r <= ins_r ? sh_r - CNT_W'(1) : sh_inc;
      if (cmd.sh_end) used_r <= ins_r ? used_r + CNT_W'(1) : used_r - CNT_W'(1);
    end
  end

  // Request capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r   <= in_op;
      cnt_r  <= in_count;
      base_r <= in_base;
    end
  end

  // List reads: entry at scan index, previous entry kept, entry to move
  always_ff @(posedge clk) begin
    if (cmd.scan_rd) begin
      cur_s_r <= rs_mem[idx_a];
      cur_l_r <= rl_mem[idx_a];
    end
    if (cmd.scan_adv) begin
      prv_s_r <= cur_s_r;
      prv_l_r <= cur_l_r;
    end
    if (cmd.sh_rd) begin
      sh_s_r <= rs_mem[src_a];
      sh_l_r <= rl_mem[src_a];
    end
  end

  // Block table: clearing pass, lookup and update
  always_ff @(posedge clk) begin
    if (cmd.blk_rd) blen_r <= blk_mem[base_r];
    if (cmd.clr_step) blk_mem[clr_r[ADDR_W-1:0]] <= '0;
    else if (cmd.alloc_hit) blk_mem[cur_s_r[ADDR_W-1:0]] <= LEN_W'(cnt_r);
    else if (cmd.free_go) blk_mem[base_r] <= '0;
  end

  // List writes: initial whole-heap range, commits and shifted entries
  always_ff @(posedge clk) begin
    if (cmd.clr_step && clr_r == '0) begin
      rs_mem[0] <= '0;
      rl_mem[0] <= LEN_W'(HEAP_SIZE);
    end else if (cmd.alloc_hit && !exact) begin
      rs_mem[idx_a] <= cur_s_r + LEN_W'(cnt_r);
      rl_mem[idx_a] <= cur_l_r - LEN_W'(cnt_r);
    end else if (cmd.free_go) begin
      if (jp) begin
        rl_mem[idxm1_a] <= prv_l_r + blen_r + (jn ? cur_l_r : '0);
      end else if (jn) begin
        rs_mem[idx_a] <= LEN_W'(base_r);
        rl_mem[idx_a] <= cur_l_r + blen_r;
      end
    end else if (cmd.sh_wr) begin
      rs_mem[sh_a] <= sh_s_r;
      rl_mem[sh_a] <= sh_l_r;
    end else if (cmd.sh_end && ins_r) begin
      rs_mem[idx_a] <= LEN_W'(base_r);
      rl_mem[idx_a] <= blen_r;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.fin) begin
      rst_r <= cmd.st;
      if (cmd.st != ST_OK) begin
        rstart_r <= '0; rsize_r <= '0; rgen_r <= '0;
      end else if (op_r == OP_ALLOC) begin
        rstart_r <= cur_s_r[7:0]; rsize_r <= cnt_r; rgen_r <= gen_r;
      end else begin
        rstart_r <= base_r; rsize_r <= blen_r; rgen_r <= '0;
      end
    end
  end

  assign res_status = rst_r;
  assign res_start  = rstart_r;
  assign res_size   = rsize_r;
  assign res_gen    = rgen_r;

endmodule

>>> hdl/ffra_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ffra_ctrl
// Sequencer: clearing pass, first-fit scan, ordered insert and list shifts.
// ----------------------------------------------------------------------------
module ffra_ctrl
  import ffra_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  logic      out_ready,
  input  ffra_sts_t sts,
  output ffra_cmd_t cmd
);

  localparam logic [2:0] S_CLR   = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_DEC   = 3'd2;
  localparam logic [2:0] S_RD    = 3'd3;
  localparam logic [2:0] S_CHK   = 3'd4;
  localparam logic [2:0] S_SHCHK = 3'd5;
  localparam logic [2:0] S_SHWR  = 3'd6;
  localparam logic [2:0] S_FIN   = 3'd7;

  logic [2:0] state_r, state_nxt;
  logic       ov_r, ov_nxt;
  logic [2:0] st_r, st_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = ov_r;

  // Next state and commands
  always_comb begin
    state_nxt = state_r;
    ov_nxt    = ov_r;
    st_nxt    = st_r;
    cmd       = '0;
    cmd.st    = st_r;
    if (ov_r && out_ready) ov_nxt = 1'b0;
    case (state_r)
      S_CLR: begin
        if (sts.clr_done) state_nxt = S_IDLE;
        else cmd.clr_step = 1'b1;
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        cmd.blk_rd  = 1'b1;
        cmd.scan_rd = 1'b1;
        if (sts.op == OP_ALLOC && sts.cnt_zero) begin
          st_nxt = ST_BAD_COUNT;
          state_nxt = S_FIN;
        end else begin
          state_nxt = S_CHK;
        end
      end
      S_RD: begin
        cmd.scan_rd = 1'b1;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        if (sts.op == OP_ALLOC) begin
          if (sts.scan_end) begin
            st_nxt = ST_NO_SPACE;
            state_nxt = S_FIN;
          end else if (sts.fits) begin
            cmd.alloc_hit = 1'b1;
            st_nxt = ST_OK;
            state_nxt = sts.exact ? S_SHCHK : S_FIN;
          end else begin
            cmd.scan_adv = 1'b1;
            state_nxt = S_RD;
          end
        end else if (sts.blk_zero) begin
          st_nxt = ST_NOT_ALLOCATED;
          state_nxt = S_FIN;
        end else if (!sts.scan_end && !sts.past) begin
          cmd.scan_adv = 1'b1;
          state_nxt = S_RD;
        end else if (sts.need_new && sts.list_full) begin
          st_nxt = ST_LIST_FULL;
          state_nxt = S_FIN;
        end else begin
          cmd.free_go = 1'b1;
          st_nxt = ST_OK;
          state_nxt = (sts.need_new || sts.both) ? S_SHCHK : S_FIN;
        end
      end
      S_SHCHK: begin
        // move one more entry, or close the shift
        if (sts.sh_more) begin
          cmd.sh_rd = 1'b1;
          state_nxt = S_SHWR;
        end else begin
          cmd.sh_end = 1'b1;
          state_nxt = S_FIN;
        end
      end
      S_SHWR: begin
        cmd.sh_wr = 1'b1;
        state_nxt = S_SHCHK;
      end
      S_FIN: begin
        // hold until the previous beat has left the result register
        if (!ov_r || out_ready) begin
          cmd.fin   = 1'b1;
          ov_nxt    = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      ov_r    <= 1'b0;
      st_r    <= ST_OK;
    end else begin
      state_r <= state_nxt;
      ov_r    <= ov_nxt;
      st_r    <= st_nxt;
    end
  end

endmodule

>>> hdl/first_fit_range_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// first_fit_range_allocator_unit
// First-fit allocator over a sorted, coalescing list of free ranges.
// ----------------------------------------------------------------------------
// channel | dir | beat
// in_*    | in  | op, count, base_index
// out_*   | out | status, block_start, block_size, generation
//
// One request at a time. The scan reads and checks each free range it steps
// past, and removing or inserting a range moves entries one at a time; a zero
// allocate count ends after decode. Worst case is an allocate that scans past 64 ranges.
// After reset a pass clears the block table; no request is taken.
// A stalled result holds in the output register; the next request is taken
// but cannot finish until the held beat is accepted.
module first_fit_range_allocator_unit
  import ffra_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  ffra_in_if.sink    in_ch,
  ffra_out_if.source out_ch
);

  ffra_cmd_t cmd;
  ffra_sts_t sts;

  ffra_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  ffra_datapath u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .sts        (sts),
    .in_op      (in_ch.op),
    .in_count   (in_ch.count),
    .in_base    (in_ch.base_index),
    .res_status (out_ch.status),
    .res_start  (out_ch.block_start),
    .res_size   (out_ch.block_size),
    .res_gen    (out_ch.generation)
  );

`ifndef SYNTHESIS
  a_hold_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && !out_ch.ready) |=> (out_ch.valid && $stable({out_ch.status,
      out_ch.block_start, out_ch.block_size, out_ch.generation})))
    else $error("result beat changed while stalled");
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status != ST_OK) |-> (out_ch.block_size == '0))
    else $error("error result carries a size");
  a_gen_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.status == ST_OK && out_ch.generation != '0)
      |-> out_ch.block_size != '0) else $error("generation without block");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> out_ch.status <= ST_LIST_FULL) else $error("unknown status");
`endif

endmodule

>>> tb/tb_first_fit_range_allocator_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_first_fit_range_allocator_unit
// Drives allocate and free requests into the first-fit range allocator under
// random idling on both channels. A shadow copy of the free list and block
// table predicts each result beat, and the beats are compared field by field.
// ----------------------------------------------------------------------------
module tb_first_fit_range_allocator_unit
  import ffra_pkg::*;
();

  typedef struct packed {
    logic       op;
    logic [8:0] count;
    logic [7:0] base_index;
  } req_t;

  typedef struct packed {
    logic [2:0] status;
    logic [7:0] block_start;
    logic [8:0] block_size;
    logic [7:0] generation;
  } rsp_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  ffra_in_if  in_ch ();
  ffra_out_if out_ch ();

  first_fit_range_allocator_unit i_dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch.sink),
    .out_ch(out_ch.source)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Shadow allocator state
  int unsigned free_start[FREE_SLOTS];
  int unsigned free_len[FREE_SLOTS];
  int unsigned free_cnt;
  int unsigned blk_len[HEAP_SIZE];
  int unsigned gen_q;

  req_t pending_reqs[$];
  rsp_t expected_rsps[$];
  int          errors = 0;
  int          send_idle_pct = 23;
  int          recv_idle_pct = 77;
  longint      cycles = 0;
  logic        in_acc = 1'b0;

  function automatic void drop_range(int unsigned pos);
    for (int unsigned i = pos; i + 1 < free_cnt; i++) begin
      free_start[i] = free_start[i+1];
      free_len[i]   = free_len[i+1];
    end
    free_cnt--;
  endfunction

  function automatic rsp_t predict_allocation(req_t r);
    rsp_t        p;
    int unsigned pos, len, i, st;
    bit          jn, jp, found;
    p     = '0;
    found = 0;
    if (r.op == OP_ALLOC) begin
      if (r.count == 0) begin
        p.status = ST_BAD_COUNT;
        return p;
      end
      for (i = 0; i < free_cnt && !found; i++) begin
        if (free_len[i] >= r.count) begin
          found = 1;
          st    = free_start[i];
          if (free_len[i] == r.count) drop_range(i);
          else begin
            free_start[i] += r.count;
            free_len[i]   -= r.count;
          end
          gen_q = (gen_q + 1) & 8'hFF;
          if (gen_q == 0) gen_q = 1;
          blk_len[st] = r.count;
          p = {ST_OK, st[7:0], r.count, gen_q[7:0]};
        end
      end
      if (!found) p.status = ST_NO_SPACE;
      return p;
    end
    if (blk_len[r.base_index] == 0) begin
      p.status = ST_NOT_ALLOCATED;
      return p;
    end
    len = blk_len[r.base_index];
    pos = 0;
    while (pos < free_cnt && free_start[pos] < r.base_index) pos++;
    jn = pos < free_cnt && r.base_index + len == free_start[pos];
    jp = pos > 0 && free_start[pos-1] + free_len[pos-1] == r.base_index;
    if (!jn && !jp && free_cnt >= FREE_SLOTS) begin
      p.status = ST_LIST_FULL;
      return p;
    end
    blk_len[r.base_index] = 0;
    if (jp) begin
      free_len[pos-1] += len;
      if (jn) begin
        free_len[pos-1] += free_len[pos];
        drop_range(pos);
      end
    end else if (jn) begin
      free_start[pos] = r.base_index;
      free_len[pos]  += len;
    end else begin
      for (i = free_cnt; i > pos; i--) begin
        free_start[i] = free_start[i-1];
        free_len[i]   = free_len[i-1];
      end
      free_start[pos] = r.base_index;
      free_len[pos]   = len;
      free_cnt++;
    end
    p = {ST_OK, r.base_index, len[8:0], 8'd0};
    return p;
  endfunction

  function automatic req_t mk(logic op, int unsigned c, int unsigned b);
    req_t r;
    r.op         = op;
    r.count      = c[8:0];
    r.base_index = b[7:0];
    return r;
  endfunction

  // Append a request to the driver queue
  function automatic void add_req(req_t r);
    pending_reqs.insert(pending_reqs.size(), r);
  endfunction

  // Note whether the request beat was taken at this edge
  always @(posedge clk) begin
    in_acc <= in_ch.valid && in_ch.ready;
  end

  // Driver: present beats at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_acc) begin
      if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        {in_ch.op, in_ch.count, in_ch.base_index} <= pending_reqs.pop_front();
        in_ch.valid <= 1'b1;
      end else begin
        in_ch.valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    out_ch.ready <= rst_n && ($urandom_range(99) >= recv_idle_pct);
  end

  // Monitor: predict on accepted requests, check accepted results
  always @(posedge clk) begin
    rsp_t got;
    rsp_t exp_r;
    if (rst_n) begin
      if (in_ch.valid && in_ch.ready)
        expected_rsps.insert(expected_rsps.size(),
          predict_allocation({in_ch.op, in_ch.count, in_ch.base_index}));
      if (out_ch.valid && out_ch.ready) begin
        got = {out_ch.status, out_ch.block_start, out_ch.block_size, out_ch.generation};
        if (expected_rsps.size() == 0) begin
          $error("unexpected result beat %h", got);
          errors++;
        end else begin
          exp_r = expected_rsps.pop_front();
          if (got.status != exp_r.status) begin
            $error("status exp %0d got %0d", exp_r.status, got.status); errors++;
          end
          if (got.block_start != exp_r.block_start) begin
            $error("block_start exp %0d got %0d", exp_r.block_start, got.block_start);
            errors++;
          end
          if (got.block_size != exp_r.block_size) begin
            $error("block_size exp %0d got %0d", exp_r.block_size, got.block_size);
            errors++;
          end
          if (got.generation != exp_r.generation) begin
            $error("generation exp %0d got %0d", exp_r.generation, got.generation);
            errors++;
          end
        end
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 3000000) begin
      $display("tb: failure");
      $finish;
    end
  end

  // Random request: about half frees at random bases, most of the rest small allocates
  function automatic req_t rand_req();
    int unsigned k;
    k = $urandom_range(99);
    if (k < 45) return mk(OP_ALLOC, $urandom_range(1, 12), $urandom_range(255));
    if (k < 50) return mk(OP_ALLOC, $urandom_range(0, 511), $urandom_range(255));
    if (k < 55) return mk(OP_FREE, $urandom_range(511), $urandom_range(255));
    return mk(OP_FREE, $urandom_range(511), $urandom_range(255));
  endfunction

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || in_ch.valid || expected_rsps.size() != 0)
      @(posedge clk);
  endtask

  initial begin
    int unsigned b;
    in_ch.valid      = 1'b0;
    in_ch.op         = 1'b0;
    in_ch.count      = '0;
    in_ch.base_index = '0;
    out_ch.ready     = 1'b0;
    for (int i = 0; i < FREE_SLOTS; i++) begin
      free_start[i] = 0; free_len[i] = 0;
    end
    for (int i = 0; i < HEAP_SIZE; i++) blk_len[i] = 0;
    free_start[0] = 0; free_len[0] = HEAP_SIZE; free_cnt = 1; gen_q = 0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: zero count, oversized, whole heap, not allocated, merges
    add_req(mk(OP_ALLOC, 0, 255));
    add_req(mk(OP_ALLOC, 511, 0));
    add_req(mk(OP_ALLOC, 257, 0));
    add_req(mk(OP_FREE, 0, 0));
    add_req(mk(OP_ALLOC, 256, 0));
    add_req(mk(OP_ALLOC, 1, 0));
    add_req(mk(OP_FREE, 0, 0));
    add_req(mk(OP_ALLOC, 1, 0));
    add_req(mk(OP_ALLOC, 2, 0));
    add_req(mk(OP_ALLOC, 3, 0));
    add_req(mk(OP_FREE, 0, 1));
    add_req(mk(OP_FREE, 0, 0));
    add_req(mk(OP_FREE, 0, 3));
    add_req(mk(OP_FREE, 0, 255));
    // Fill the list: 128 two-slot blocks, free every other one -> list full
    for (int i = 0; i < 128; i++) add_req(mk(OP_ALLOC, 2, 0));
    for (int i = 0; i < 64; i++) add_req(mk(OP_FREE, 0, 4 * i));
    add_req(mk(OP_FREE, 0, 254));
    add_req(mk(OP_FREE, 0, 2));
    for (int i = 1; i < 128; i += 2) add_req(mk(OP_FREE, 0, 2 * i));

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 23 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 23 : 0;
      for (int i = 0; i < 130; i++) add_req(rand_req());
      // Frees aimed at likely block starts
      for (int i = 0; i < 45; i++) begin
        b = $urandom_range(31) * $urandom_range(1, 8);
        add_req(mk(OP_FREE, $urandom_range(511), b % 256));
      end
      wait_drained();
    end
    repeat (400) @(posedge clk);
    if (errors == 0 && expected_rsps.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
